@@ rtl/core/matrix3x3_inverse_assert.svh @@
// Assertion macros shared by the matrix inverse checkers.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MI3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MI3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mi3_pkg.sv @@
// Shared constants for the 3x3 matrix inverse.
package mi3_pkg;

  localparam int NUM_ELEMS = 9;
  // Multiplier operand slice width.
  localparam int MUL_CHUNK = 32;

  // Cofactor k = m[a]*m[b] - m[c]*m[d], elements numbered row by row.
  localparam int COF_IDX [NUM_ELEMS][4] = '{
    '{4, 8, 5, 7},
    '{5, 6, 3, 8},
    '{3, 7, 4, 6},
    '{2, 7, 1, 8},
    '{0, 8, 2, 6},
    '{1, 6, 0, 7},
    '{1, 5, 2, 4},
    '{2, 3, 0, 5},
    '{0, 4, 1, 3}
  };

endpackage

@@ rtl/core/mi3_if.sv @@
// Handshake interfaces for the matrix and inverse channels.
interface mi3_in_if #(parameter int ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface mi3_out_if #(parameter int ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic                         singular;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, output ready);
endinterface

@@ rtl/core/mi3_mul.sv @@
// Two-stage signed multiplier built from 33x33 slice products.
module mi3_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  output logic signed [AW+BW-1:0]   p_o
);
  import mi3_pkg::*;

  localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AXW = NA * MUL_CHUNK;
  localparam int BXW = NB * MUL_CHUNK;
  localparam int SW  = AXW + BXW;
  localparam int PW  = AW + BW;

  logic signed [AXW-1:0]         a_ext;
  logic signed [BXW-1:0]         b_ext;
  logic signed [MUL_CHUNK:0]     a_ch [NA];
  logic signed [MUL_CHUNK:0]     b_ch [NB];
  logic signed [2*MUL_CHUNK+1:0] pp_q [NA][NB];
  logic signed [SW-1:0]          sum;
  logic signed [PW-1:0]          p_q;

  assign a_ext = AXW'(a_i);
  assign b_ext = BXW'(b_i);

  // Top slice carries the sign, lower slices are unsigned.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      a_ch[i] = {(i == NA - 1) ? a_ext[AXW-1] : 1'b0, a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
    end
    for (int j = 0; j < NB; j++) begin
      b_ch[j] = {(j == NB - 1) ? b_ext[BXW-1] : 1'b0, b_ext[j*MUL_CHUNK +: MUL_CHUNK]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_ch[i] * b_ch[j];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp_q[i][j]) <<< (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum[PW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/mi3_lane.sv @@
// One divider lane: magnitude prep, then one quotient bit per stage.
module mi3_lane #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int CW = 2 * W + 1,
  parameter int DW = 3 * W + 3,
  parameter int RW = DW + W
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] cof_i,
  input  logic signed [DW-1:0] det_i,
  output logic [W-1:0]         quo_o,
  output logic                 neg_o,
  output logic                 over_o
);

  logic [CW-1:0] abs_c;
  logic [DW-1:0] abs_d;
  logic [RW-1:0] num;
  logic          neg_d;
  logic          over_d;

  logic [RW-1:0] r_q    [W];
  logic [DW-1:0] nd_q   [W];
  logic [W-1:0]  q_q    [W+1];
  logic          neg_q  [W+1];
  logic          over_q [W+1];

  always_comb begin
    abs_c  = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
    abs_d  = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
    num    = RW'(abs_c) << (2 * F);
    neg_d  = cof_i[CW-1] ^ det_i[DW-1];
    // quotient of 2^W or more saturates in any case
    over_d = num >= (RW'(abs_d) << W);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= num;
      nd_q[0]   <= abs_d;
      q_q[0]    <= '0;
      neg_q[0]  <= neg_d;
      over_q[0] <= over_d;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    logic [RW-1:0] trial;
    logic          fits;

    assign trial = RW'(nd_q[k-1]) << (W - k);
    assign fits  = r_q[k-1] >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]    <= q_q[k-1] | (fits ? (W'(1) << (W - k)) : W'(0));
        neg_q[k]  <= neg_q[k-1];
        over_q[k] <= over_q[k-1];
      end
    end

    if (k < W) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k]  <= fits ? r_q[k-1] - trial : r_q[k-1];
          nd_q[k] <= nd_q[k-1];
        end
      end
    end
  end

  assign quo_o  = q_q[W];
  assign neg_o  = neg_q[W];
  assign over_o = over_q[W];

endmodule

@@ rtl/core/matrix3x3_inverse.sv @@
// 3x3 fixed-point matrix inverse: adjugate over determinant, nine divider lanes.
//
//   channel | dir | payload                          | accepted when
//   mat_i   | in  | m00..m22, Q(W-F).F signed       | valid && ready
//   inv_o   | out | r00..r22 saturated, singular    | valid && ready
//
// One matrix per cycle sustained while inv_o takes results; each passes the cofactor,
// determinant and bit-per-stage divider stages, then the output register.
// Reset clears stage valids and the output buffer only; datapath has no reset.
// The whole pipe advances together; an output register plus a skid entry
// absorb one stalled result, so mat_i.ready drops only when both hold data.
module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi3_in_if.sink    mat_i,
  mi3_out_if.source inv_o
);
  import mi3_pkg::*;

  localparam int W   = ELEM_WIDTH;
  localparam int CW  = 2 * W + 1;              // exact cofactor
  localparam int DW  = 3 * W + 3;              // exact determinant
  localparam int NW  = CW + 2 * FRAC_BITS;     // scaled numerator
  localparam int RW  = (NW > DW + W) ? NW : DW + W;
  localparam int NV  = W + 7;                  // pipeline stages before output

  logic                 en;
  logic [NV-1:0]        v_q;
  logic signed [W-1:0]  m [NUM_ELEMS];
  logic                 out_valid_q, skid_valid_q;

  assign en          = !skid_valid_q;
  assign mat_i.ready = en;

  assign m[0] = mat_i.m00;  assign m[1] = mat_i.m01;  assign m[2] = mat_i.m02;
  assign m[3] = mat_i.m10;  assign m[4] = mat_i.m11;  assign m[5] = mat_i.m12;
  assign m[6] = mat_i.m20;  assign m[7] = mat_i.m21;  assign m[8] = mat_i.m22;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NV-2:0], mat_i.valid};
    end
  end

  // ---- stages 0..2: 2x2 minors, then cofactor subtract
  logic signed [2*W-1:0] prod_a [NUM_ELEMS];
  logic signed [2*W-1:0] prod_b [NUM_ELEMS];
  logic signed [CW-1:0]  cof_q  [NUM_ELEMS];

  for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_cof
    mi3_mul #(.AW(W), .BW(W)) u_mul_a (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m[COF_IDX[k][0]]),
      .b_i   (m[COF_IDX[k][1]]),
      .p_o   (prod_a[k])
    );
    mi3_mul #(.AW(W), .BW(W)) u_mul_b (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m[COF_IDX[k][2]]),
      .b_i   (m[COF_IDX[k][3]]),
      .p_o   (prod_b[k])
    );
  end

  // row 0 rides along to meet its cofactors
  logic signed [W-1:0] row0_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        row0_q[0][j] <= m[j];
        row0_q[1][j] <= row0_q[0][j];
        row0_q[2][j] <= row0_q[1][j];
      end
      for (int k = 0; k < NUM_ELEMS; k++) begin
        cof_q[k] <= CW'(prod_a[k]) - CW'(prod_b[k]);
      end
    end
  end

  // ---- stages 3..5: determinant along row 0
  logic signed [W+CW-1:0] dprod [3];
  logic signed [CW-1:0]   cof_d_q [3][NUM_ELEMS];
  logic signed [DW-1:0]   det_q;

  for (genvar j = 0; j < 3; j++) begin : g_det
    mi3_mul #(.AW(W), .BW(CW)) u_mul_d (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (row0_q[2][j]),
      .b_i   (cof_q[j]),
      .p_o   (dprod[j])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ELEMS; k++) begin
        cof_d_q[0][k] <= cof_q[k];
        cof_d_q[1][k] <= cof_d_q[0][k];
        cof_d_q[2][k] <= cof_d_q[1][k];
      end
      det_q <= DW'(dprod[0]) + DW'(dprod[1]) + DW'(dprod[2]);
    end
  end

  // ---- stages 6..6+W: nine divider lanes, singular flag alongside
  logic [W-1:0] quo  [NUM_ELEMS];
  logic         neg  [NUM_ELEMS];
  logic         over [NUM_ELEMS];
  logic [W:0]   zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= {zero_q[W-1:0], det_q == '0};
    end
  end

  // lane for inverse (i,j) divides the adjugate entry, cofactor (j,i)
  for (genvar l = 0; l < NUM_ELEMS; l++) begin : g_lane
    mi3_lane #(.W(W), .F(FRAC_BITS), .CW(CW), .DW(DW), .RW(RW)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .cof_i  (cof_d_q[2][(l % 3) * 3 + (l / 3)]),
      .det_i  (det_q),
      .quo_o  (quo[l]),
      .neg_o  (neg[l]),
      .over_o (over[l])
    );
  end

  // ---- merge: sign, saturation, singular override
  logic [W-1:0] res_d [NUM_ELEMS];
  logic         push;

  assign push = en && v_q[NV-1];

  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] mag;
    for (int l = 0; l < NUM_ELEMS; l++) begin
      lim = neg[l] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
      mag = (over[l] || quo[l] > lim) ? lim : quo[l];
      res_d[l] = zero_q[W] ? '0 : (neg[l] ? W'(-mag) : mag);
    end
  end

  // ---- output register and skid entry
  logic         out_sing_q, skid_sing_q;
  logic [W-1:0] out_q  [NUM_ELEMS];
  logic [W-1:0] skid_q [NUM_ELEMS];
  logic         out_move;

  assign out_move = !out_valid_q || inv_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_move) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      if (skid_valid_q) begin
        out_q      <= skid_q;
        out_sing_q <= skid_sing_q;
        skid_q      <= res_d;
        skid_sing_q <= zero_q[W];
      end else begin
        out_q      <= res_d;
        out_sing_q <= zero_q[W];
      end
    end else if (push) begin
      skid_q      <= res_d;
      skid_sing_q <= zero_q[W];
    end
  end

  assign inv_o.valid    = out_valid_q;
  assign inv_o.singular = out_sing_q;
  assign inv_o.r00 = out_q[0];  assign inv_o.r01 = out_q[1];  assign inv_o.r02 = out_q[2];
  assign inv_o.r10 = out_q[3];  assign inv_o.r11 = out_q[4];  assign inv_o.r12 = out_q[5];
  assign inv_o.r20 = out_q[6];  assign inv_o.r21 = out_q[7];  assign inv_o.r22 = out_q[8];

endmodule

@@ rtl/core/mi3_checker.sv @@
// Port-level checks for the matrix inverse, bound to the top level.
`include "matrix3x3_inverse_assert.svh"

module mi3_checker #(
  parameter int ELEM_WIDTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic                    singular_i,
  input logic [9*ELEM_WIDTH-1:0] res_i
);

  `MI3_ASSERT_IMP(a_sing_zero, out_valid_i && singular_i, res_i == '0, "singular result not zero")
  `MI3_ASSERT_IMP(a_stall_cause, in_valid_i && !in_ready_i, out_valid_i, "input stalled with no waiting result")
  `MI3_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped under stall")
  `MI3_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(res_i) && $stable(singular_i), "result changed under stall")

endmodule

bind matrix3x3_inverse mi3_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mi3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (mat_i.valid),
  .in_ready_i  (mat_i.ready),
  .out_valid_i (inv_o.valid),
  .out_ready_i (inv_o.ready),
  .singular_i  (inv_o.singular),
  .res_i       ({inv_o.r00, inv_o.r01, inv_o.r02, inv_o.r10, inv_o.r11, inv_o.r12,
                 inv_o.r20, inv_o.r21, inv_o.r22})
);

@@ bench/testbench.sv @@
// Self-checking bench for the 3x3 fixed-point matrix inverse.
module testbench;
  import mi3_pkg::*;

  localparam int W        = 32;
  localparam int F        = 16;
  localparam int LATENCY  = W + 8;
  localparam int N_RANDOM = 1500;
  localparam int WDOG_MAX = 5000;
  localparam int LONG_HOLD   = 250;  // receiver back-pressure stretch
  localparam int HOLD_AT     = 300;  // results seen before the long hold
  localparam int DRAIN_AT    = 800;  // matrices sent before the drain pause
  localparam logic [W-1:0] ONE  = 32'h0001_0000;
  localparam logic [W-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [W-1:0] MINV = 32'h8000_0000;

  typedef struct packed {
    logic [8:0][W-1:0] e;
  } matrix_t;

  typedef struct packed {
    logic [8:0][W-1:0] r;
    logic              singular;
  } inverse_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mi3_in_if  #(.ELEM_WIDTH(W)) mat_if ();
  mi3_out_if #(.ELEM_WIDTH(W)) inv_if ();

  matrix3x3_inverse #(.ELEM_WIDTH(W), .FRAC_BITS(F)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .mat_i (mat_if.sink),
    .inv_o (inv_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_t  pending_mats[$];
  inverse_t expected_invs[$];
  int n_sent = 0, n_recv = 0, n_singular = 0, n_errors = 0;
  bit stim_done = 1'b0;

  // Exact adjugate over determinant, truncated toward zero, then saturated.
  function automatic inverse_t invert_matrix(matrix_t a);
    logic signed [127:0] x [9];
    logic signed [127:0] cof [9];
    logic signed [127:0] det, q;
    inverse_t res;
    for (int k = 0; k < 9; k++) x[k] = signed'(a.e[k]);
    for (int k = 0; k < 9; k++)
      cof[k] = x[COF_IDX[k][0]] * x[COF_IDX[k][1]] - x[COF_IDX[k][2]] * x[COF_IDX[k][3]];
    det = x[0] * cof[0] + x[1] * cof[1] + x[2] * cof[2];
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        q = (cof[j*3+i] <<< (2*F)) / det;   // SV signed divide truncates toward zero
        if (q > signed'(128'(MAXV)))                res.r[i*3+j] = MAXV;
        else if (q < -signed'(128'({1'b0, MINV}))) res.r[i*3+j] = MINV;
        else                                        res.r[i*3+j] = q[W-1:0];
      end
    return res;
  endfunction

  function automatic logic [W-1:0] pick_extreme();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return '0;
      3: return ONE;
      4: return -ONE;
      default: return W'($urandom_range(0, 3)) - 1;
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int src, dst;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1:    m.e[k] = $urandom();                       // full range
        2:       m.e[k] = pick_extreme();
        default: m.e[k] = W'(signed'($urandom_range(0, 'h3ffff)) - 'h20000);
      endcase
    end
    // kinds 4..7 get a strong diagonal, random sign
    if (kind >= 4 && kind <= 7)
      for (int d = 0; d < 3; d++)
        m.e[d*4] = ($urandom_range(0, 1) ? 1 : -1) * signed'($urandom_range('h40000, 'h400000));
    if (kind == 8) begin
      // near-singular: each element of one row is copied from another row or zeroed
      src = $urandom_range(0, 2);
      dst = (src + $urandom_range(1, 2)) % 3;
      for (int c = 0; c < 3; c++)
        m.e[dst*3+c] = $urandom_range(0, 1) ? m.e[src*3+c] : '0;
    end
    return m;
  endfunction

  function automatic matrix_t diag(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    matrix_t m;
    m = '0;
    m.e[0] = a;
    m.e[4] = b;
    m.e[8] = c;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed corners first, then mostly random matrices.
  // ---------------------------------------------------------------------------
  initial begin
    matrix_t m;
    int settle;
    pending_mats.push_back(diag(ONE, ONE, ONE));        // identity
    pending_mats.push_back('0);                          // all zero -> singular
    pending_mats.push_back(diag(-ONE, ONE, ONE));        // negative determinant
    pending_mats.push_back(diag(1, 1, 1));               // tiny det -> positive saturation
    pending_mats.push_back(diag(-1, 1, 1));              // tiny det, negative saturation
    pending_mats.push_back(diag(MAXV, MAXV, MAXV));      // huge det, results near zero
    pending_mats.push_back(diag(MINV, MINV, MINV));
    pending_mats.push_back(diag(MINV, MAXV, 1));
    pending_mats.push_back(diag(2*ONE, 4*ONE, -8*ONE)); // exact fractional inverse
    for (int k = 0; k < 9; k++) m.e[k] = MAXV;          // rank one -> singular
    pending_mats.push_back(m);
    for (int k = 0; k < 9; k++) m.e[k] = MINV;
    pending_mats.push_back(m);
    for (int k = 0; k < 9; k++) m.e[k] = '1;
    pending_mats.push_back(m);
    m = '0;                                               // permutation matrix
    m.e[1] = ONE; m.e[5] = ONE; m.e[6] = ONE;
    pending_mats.push_back(m);
    for (int k = 0; k < 9; k++) m.e[k] = (k % 2) ? MAXV : MINV;
    pending_mats.push_back(m);
    for (int k = 0; k < 9; k++) m.e[k] = W'(k + 1) * ONE;  // 1..9 -> singular
    pending_mats.push_back(m);
    for (int k = 0; k < 6; k++) pending_mats.push_back(random_matrix());
    for (int n = 0; n < N_RANDOM; n++) pending_mats.push_back(random_matrix());

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_mats.size() == 0 && !mat_if.valid && expected_invs.size() == 0);
    settle = 0;
    while (settle < LATENCY + 10) begin
      @(posedge clk_i);
      settle++;
    end
    stim_done = 1'b1;
    $display("Inverted %0d matrices (%0d singular), directed corners plus random", n_sent,
             n_singular);
    $display("Idle gaps on both sides, one long output stall, one full drain pause");
    if (n_errors == 0 && expected_invs.size() == 0 && n_recv == n_sent)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers matrices with random gaps; calm stretches have no gaps.
  // At DRAIN_AT it holds back until every outstanding inverse has come out.
  // ---------------------------------------------------------------------------
  int  send_gap = 0;
  logic next_valid;
  matrix_t next_mat;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_if.valid <= 1'b0;
      {mat_if.m00, mat_if.m01, mat_if.m02, mat_if.m10, mat_if.m11, mat_if.m12,
       mat_if.m20, mat_if.m21, mat_if.m22} <= '0;
    end else begin
      next_valid = mat_if.valid;
      next_mat = {mat_if.m22, mat_if.m21, mat_if.m20, mat_if.m12, mat_if.m11, mat_if.m10,
                  mat_if.m02, mat_if.m01, mat_if.m00};
      if (mat_if.valid && mat_if.ready) begin
        expected_invs.push_back(invert_matrix(next_mat));
        n_sent++;
        next_valid = 1'b0;
        send_gap = ((n_sent / 200) % 2) ? 0 : $urandom_range(0, 14);
      end
      if (!next_valid) begin
        if (send_gap > 0)
          send_gap--;
        else if (pending_mats.size() != 0 &&
                 !(n_sent == DRAIN_AT && expected_invs.size() != 0)) begin
          next_mat = pending_mats.pop_front();
          next_valid = 1'b1;
        end
      end
      mat_if.valid <= next_valid;
      {mat_if.m22, mat_if.m21, mat_if.m20, mat_if.m12, mat_if.m11, mat_if.m10,
       mat_if.m02, mat_if.m01, mat_if.m00} <= next_mat;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random ready stalls, one long hold so the pipe backs up,
  // and a field-by-field compare against the oldest expected inverse.
  // ---------------------------------------------------------------------------
  int recv_wait = 0;
  inverse_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_if.ready <= 1'b0;
    end else begin
      if (inv_if.valid && inv_if.ready) begin
        got.r = {inv_if.r22, inv_if.r21, inv_if.r20, inv_if.r12, inv_if.r11, inv_if.r10,
                 inv_if.r02, inv_if.r01, inv_if.r00};
        got.singular = inv_if.singular;
        n_recv++;
        if (expected_invs.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("Unexpected inverse transaction #%0d", n_recv);
        end else begin
          want = expected_invs.pop_front();
          if (want.singular) n_singular++;
          if (got.singular !== want.singular) begin
            n_errors++;
            if (n_errors <= 10)
              $display("Inverse #%0d singular: expected %0b got %0b", n_recv,
                       want.singular, got.singular);
          end
          for (int k = 0; k < 9; k++)
            if (got.r[k] !== want.r[k]) begin
              n_errors++;
              if (n_errors <= 10)
                $display("Inverse #%0d r%0d%0d: expected %h got %h", n_recv, k / 3, k % 3,
                         want.r[k], got.r[k]);
            end
        end
        if (n_recv == HOLD_AT) recv_wait = LONG_HOLD;
        else recv_wait = ((n_recv / 250) % 2) ? 0 : $urandom_range(0, 14);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      inv_if.ready <= (recv_wait == 0);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready) || !rst_ni)
      quiet_cycles <= 0;
    else if (!stim_done) begin
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Timeout: no transaction for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
